// File: rtl/kbrc_pkg.sv
// ----------------------------------------------------------------------------
// kbrc_pkg
// Shared types and constants for the keyboard repeat and command controller.
// ----------------------------------------------------------------------------
package kbrc_pkg;

  // Key identities are held at most this wide
  localparam int KEY_MAX_BITS = 16;

  typedef logic [KEY_MAX_BITS-1:0] key_t;
  typedef logic [7:0]              byte_t;
  typedef logic [15:0]             ms16_t;

  // Event kinds
  typedef enum logic [1:0] {
    ACT_PRESS   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_HOST    = 2'd3
  } action_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    action_t     action;
    key_t        key;
    byte_t       scancode;
    logic [3:0]  tick_ms;
    logic [2:0]  edges;    // falling edges of the host byte on the line, plus one
  } q_item_t;

  // Configuration register contents
  typedef struct packed {
    ms16_t rep_delay;
    ms16_t rep_period;
    byte_t ack_byte;
    ms16_t beep_ms;
  } cfg_t;

endpackage

// File: rtl/kbrc_front.sv
// ----------------------------------------------------------------------------
// kbrc_front
// Accepts input items, masks the key, counts host byte line edges and
// queues the classified item for the back part in a two-entry queue.
// ----------------------------------------------------------------------------
module kbrc_front import kbrc_pkg::*; #(
  parameter int KEY_ID_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_action,
  input  logic [KEY_ID_BITS-1:0] in_key_id,
  input  logic [7:0]             in_scancode,
  input  logic [3:0]             in_tick_ms,
  input  logic [7:0]             in_host_byte,
  output logic                   q_valid,
  output q_item_t                q_head,
  input  logic                   q_pop
);

  localparam int KEY_W = (KEY_ID_BITS < KEY_MAX_BITS) ? KEY_ID_BITS : KEY_MAX_BITS;

  // Falling edges between neighbouring bits, plus the start edge
  function automatic logic [2:0] line_edges(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd1;
    for (int i = 1; i < 8; i++) begin
      if (b[i-1] && !b[i]) n = n + 3'd1;
    end
    return n;
  endfunction

  q_item_t    item;
  q_item_t    q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  // Classification
  always_comb begin
    item.action   = action_t'(in_action);
    item.key      = KEY_MAX_BITS'(in_key_id[KEY_W-1:0]);
    item.scancode = in_scancode;
    item.tick_ms  = in_tick_ms;
    item.edges    = line_edges(in_host_byte);
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_head   = q_mem_r[rd_ptr_r];

  // Queue pointers
  always_comb begin
    wr_ptr_nxt = push  ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = 2'(cnt_r + {1'b0, push} - {1'b0, q_pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= item;
  end

endmodule

// File: rtl/kbrc_back.sv
// ----------------------------------------------------------------------------
// kbrc_back
// Carries out queued items: key hold state, auto-repeat timers, host
// command decoding, lamps and beep countdown, and the result register.
// ----------------------------------------------------------------------------
module kbrc_back import kbrc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  q_item_t    q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_byte_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_last,
  output logic [5:0] out_led_mask,
  output logic       out_beep_active
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_REP  = 1'b1;

  // Command codes, taken as the complement of the edge counter
  localparam logic [3:0] CMD_CLEAR_A = 4'd14;
  localparam logic [3:0] CMD_ERR     = 4'd13;
  localparam logic [3:0] CMD_BEEP    = 4'd12;
  localparam logic [3:0] CMD_G00     = 4'd11;
  localparam logic [3:0] CMD_PREFIX  = 4'd10;
  localparam logic [3:0] CMD_CLEAR_B = 4'd9;
  localparam logic [3:0] CMD_G01     = 4'd8;
  localparam logic [3:0] CMD_G02     = 4'd7;
  localparam logic [3:0] CMD_G03     = 4'd6;
  localparam logic [3:0] CMD_G04     = 4'd5;
  localparam logic [3:0] REP_CAP_M1  = 4'd14;

  function automatic logic pos17(input logic signed [16:0] v);
    return !v[16] && (v != 17'sd0);
  endfunction

  logic                st_r, st_nxt;
  logic                once_r, once_nxt;
  logic [3:0]          rcnt_r, rcnt_nxt;
  key_t                held_key_r, held_key_nxt;
  byte_t               held_sc_r, held_sc_nxt;
  logic signed [16:0]  delay_r, delay_nxt;
  logic signed [16:0]  period_r, period_nxt;
  logic [3:0]          edge_r, edge_nxt;
  logic [5:0]          lamp_r, lamp_nxt;
  ms16_t               beep_r, beep_nxt;

  logic                obv_r, obyte_valid_r, olast_r, obeep_r;
  byte_t               obyte_r;
  logic [5:0]          oled_r;

  logic                out_free, emit, e_bv, e_last;
  byte_t               e_byte;
  logic signed [16:0]  eff_d, eff_p, tk, d, pp, p, sum;
  logic [3:0]          edge_sum, cmd;
  logic [5:0]          lamp_tog;

  assign out_free = !obv_r || !out_stall;

  always_comb begin
    eff_d = (cfg.rep_delay  == 16'd0) ? 17'sd1 : signed'({1'b0, cfg.rep_delay});
    eff_p = (cfg.rep_period == 16'd0) ? 17'sd1 : signed'({1'b0, cfg.rep_period});
    tk    = signed'({13'd0, q_head.tick_ms});
    d     = delay_r - tk;
    pp    = eff_p + d;
    p     = period_r - tk;
    sum   = period_r + eff_p;
    edge_sum = 4'(edge_r + {1'b0, q_head.edges});
    cmd      = ~edge_sum;
    lamp_tog = lamp_r ^ 6'h01;
  end

  // Item execution and repeat sequencing
  always_comb begin
    st_nxt       = st_r;
    once_nxt     = once_r;
    rcnt_nxt     = rcnt_r;
    held_key_nxt = held_key_r;
    held_sc_nxt  = held_sc_r;
    delay_nxt    = delay_r;
    period_nxt   = period_r;
    edge_nxt     = edge_r;
    lamp_nxt     = lamp_r;
    beep_nxt     = beep_r;
    q_pop        = 1'b0;
    emit         = 1'b0;
    e_bv         = 1'b0;
    e_byte       = 8'd0;
    e_last       = 1'b1;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          emit  = 1'b1;
          unique case (q_head.action)
            ACT_PRESS: begin
              held_key_nxt = q_head.key;
              held_sc_nxt  = q_head.scancode;
              delay_nxt    = eff_d;
              period_nxt   = 17'sd0;
              e_bv         = 1'b1;
              e_byte       = q_head.scancode;
            end
            ACT_RELEASE: begin
              if (held_key_r == q_head.key) begin
                held_key_nxt = '0;
                held_sc_nxt  = '0;
                delay_nxt    = 17'sd0;
                period_nxt   = 17'sd0;
              end
            end
            ACT_HOST: begin
              e_bv     = 1'b1;
              e_byte   = cfg.ack_byte;
              edge_nxt = (cmd == CMD_PREFIX) ? edge_sum : 4'd0;
              unique case (cmd)
                CMD_CLEAR_A, CMD_CLEAR_B: begin
                  lamp_nxt = 6'd0;
                  beep_nxt = 16'd0;
                end
                CMD_ERR: begin
                  lamp_nxt = lamp_tog;
                  if (lamp_tog[0]) beep_nxt = cfg.beep_ms;
                end
                CMD_BEEP: beep_nxt = cfg.beep_ms;
                CMD_G00:  lamp_nxt = lamp_r ^ 6'h02;
                CMD_G01:  lamp_nxt = lamp_r ^ 6'h04;
                CMD_G02:  lamp_nxt = lamp_r ^ 6'h08;
                CMD_G03:  lamp_nxt = lamp_r ^ 6'h10;
                CMD_G04:  lamp_nxt = lamp_r ^ 6'h20;
                default: ;
              endcase
            end
            ACT_TICK: begin
              beep_nxt = (beep_r > 16'(q_head.tick_ms)) ?
                         16'(beep_r - 16'(q_head.tick_ms)) : 16'd0;
              if (held_key_r != '0) begin
                if (pos17(delay_r)) begin
                  // initial delay running
                  if (pos17(d)) begin
                    delay_nxt = d;
                  end else begin
                    delay_nxt = 17'sd0;
                    e_bv      = 1'b1;
                    e_byte    = held_sc_r;
                    if (pos17(pp)) begin
                      period_nxt = pp;
                    end else begin
                      // overshoot beyond a whole period: one more byte
                      e_last     = 1'b0;
                      period_nxt = eff_p;
                      st_nxt     = ST_REP;
                      once_nxt   = 1'b1;
                      rcnt_nxt   = 4'd1;
                    end
                  end
                end else begin
                  // repeat period running
                  period_nxt = p;
                  if (!pos17(p)) begin
                    emit     = 1'b0;
                    st_nxt   = ST_REP;
                    once_nxt = 1'b0;
                    rcnt_nxt = 4'd0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_REP: begin
        if (out_free) begin
          emit   = 1'b1;
          e_bv   = 1'b1;
          e_byte = held_sc_r;
          if (once_r) begin
            st_nxt = ST_IDLE;
          end else begin
            e_last     = pos17(sum) || (rcnt_r == REP_CAP_M1);
            period_nxt = (pos17(sum) || !e_last) ? sum : eff_p;
            rcnt_nxt   = 4'(rcnt_r + 4'd1);
            if (e_last) st_nxt = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control and device state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      once_r     <= 1'b0;
      rcnt_r     <= 4'd0;
      held_key_r <= '0;
      held_sc_r  <= '0;
      delay_r    <= 17'sd0;
      period_r   <= 17'sd0;
      edge_r     <= 4'd0;
      lamp_r     <= 6'd0;
      beep_r     <= 16'd0;
      obv_r      <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      once_r     <= once_nxt;
      rcnt_r     <= rcnt_nxt;
      held_key_r <= held_key_nxt;
      held_sc_r  <= held_sc_nxt;
      delay_r    <= delay_nxt;
      period_r   <= period_nxt;
      edge_r     <= edge_nxt;
      lamp_r     <= lamp_nxt;
      beep_r     <= beep_nxt;
      if (emit) obv_r <= 1'b1;
      else if (!out_stall) obv_r <= 1'b0;
    end
  end

  // Result register payload; lamps and beep show the state after the item
  always_ff @(posedge clk) begin
    if (emit) begin
      obyte_valid_r <= e_bv;
      obyte_r       <= e_byte;
      olast_r       <= e_last;
      oled_r        <= lamp_nxt;
      obeep_r       <= (beep_nxt != 16'd0);
    end
  end

  assign out_valid       = obv_r;
  assign out_byte_valid  = obyte_valid_r;
  assign out_tx_byte     = obyte_r;
  assign out_last        = olast_r;
  assign out_led_mask    = oled_r;
  assign out_beep_active = obeep_r;

`ifndef SYNTHESIS
  // repeats only run for a held key
  a_rep_held: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_REP |-> held_key_r != '0)
    else $error("repeat sequence without a held key");

  // a tick never gives more than fifteen bytes
  a_rep_cap: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_REP |-> rcnt_r <= REP_CAP_M1)
    else $error("repeat count beyond cap");

  // delay and period timers never run together
  a_timers: assert property (@(posedge clk) disable iff (!rst_n)
    !(pos17(delay_r) && pos17(period_r)))
    else $error("delay and period both running");

  // no item is taken while repeats are still being sent
  a_no_pop_rep: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_REP |-> !q_pop)
    else $error("item taken during repeat sequence");
`endif

endmodule

// File: rtl/keyboard_repeat_and_command_top.sv
// ----------------------------------------------------------------------------
// keyboard_repeat_and_command_top
// Keyboard controller: key auto-repeat, host command decoding, lamps, beep.
// ----------------------------------------------------------------------------
// Items enter a two-entry queue after the key is masked and the host byte's
// line edges are counted, so in_stall rises only when that queue is full.
// An accepted item reaches the back part in the next cycle; the back part takes
// it once the output register is free and loads its first result into the
// output register at that edge. Further repeat bytes of a tick follow one
// per cycle while out_stall is low. A tick whose repeats come from the period
// timer first updates the timer without a result, then sends its bytes from
// the repeat state, at most fifteen repeat bytes for one tick.
// Results wait in the output register while out_stall is high, and the back
// part holds there. Configuration writes take effect at the next item.
// ----------------------------------------------------------------------------
module keyboard_repeat_and_command_top import kbrc_pkg::*; #(
  parameter int KEY_ID_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_action,
  input  logic [KEY_ID_BITS-1:0] in_key_id,
  input  logic [7:0]             in_scancode,
  input  logic [3:0]             in_tick_ms,
  input  logic [7:0]             in_host_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_byte_valid,
  output logic [7:0]             out_tx_byte,
  output logic                   out_last,
  output logic [5:0]             out_led_mask,
  output logic                   out_beep_active
);

  localparam logic [1:0] CFG_REPEAT_DELAY  = 2'd0;
  localparam logic [1:0] CFG_REPEAT_PERIOD = 2'd1;
  localparam logic [1:0] CFG_TYPE_CODE     = 2'd2;
  localparam logic [1:0] CFG_BEEP_MS       = 2'd3;

  cfg_t    cfg_r;
  logic    q_valid, q_pop;
  q_item_t q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rep_delay  <= 16'd500;
      cfg_r.rep_period <= 16'd100;
      cfg_r.ack_byte   <= 8'd128;
      cfg_r.beep_ms    <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPEAT_DELAY:  cfg_r.rep_delay  <= cfg_wdata;
        CFG_REPEAT_PERIOD: cfg_r.rep_period <= cfg_wdata;
        CFG_TYPE_CODE:     cfg_r.ack_byte   <= cfg_wdata[7:0];
        CFG_BEEP_MS:       cfg_r.beep_ms    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  kbrc_front #(
    .KEY_ID_BITS (KEY_ID_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_key_id    (in_key_id),
    .in_scancode  (in_scancode),
    .in_tick_ms   (in_tick_ms),
    .in_host_byte (in_host_byte),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop)
  );

  kbrc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte_valid  (out_byte_valid),
    .out_tx_byte     (out_tx_byte),
    .out_last        (out_last),
    .out_led_mask    (out_led_mask),
    .out_beep_active (out_beep_active)
  );

endmodule

// File: tb/keyboard_repeat_and_command_top_tb.sv
// ----------------------------------------------------------------------------
// keyboard_repeat_and_command_top_tb
// Self-checking bench for the keyboard repeat and command controller. Key
// presses, releases, millisecond ticks and host command bytes are driven with
// random gaps while the result side stalls at random. An in-bench predictor
// tracks the held key, repeat timers, command edge counter, lamps and beep
// countdown, and every result item is compared field by field against it.
// ----------------------------------------------------------------------------
module keyboard_repeat_and_command_top_tb import kbrc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_BITS     = 16;
  localparam int MAX_BYTES    = 15;
  localparam int DRAIN_CYCLES = 20;
  localparam int ERR_PRINTS   = 100;

  // Configuration register indexes
  localparam logic [1:0] REG_REPEAT_DELAY  = 2'd0;
  localparam logic [1:0] REG_REPEAT_PERIOD = 2'd1;
  localparam logic [1:0] REG_TYPE_CODE     = 2'd2;
  localparam logic [1:0] REG_BEEP_MS       = 2'd3;

  // Command codes, taken as 15 minus the edge counter
  localparam logic [3:0] CMD_ALL_OFF     = 4'd14;
  localparam logic [3:0] CMD_ALL_OFF_ALT = 4'd9;
  localparam logic [3:0] CMD_ERROR_LAMP  = 4'd13;
  localparam logic [3:0] CMD_BEEP        = 4'd12;
  localparam logic [3:0] CMD_PREFIX      = 4'd10;
  localparam logic [3:0] CMD_G00         = 4'd11;
  localparam logic [3:0] CMD_G01         = 4'd8;
  localparam logic [3:0] CMD_G02         = 4'd7;
  localparam logic [3:0] CMD_G03         = 4'd6;
  localparam logic [3:0] CMD_G04         = 4'd5;

  // Lamp bits
  localparam logic [5:0] LAMP_ERROR = 6'h01;
  localparam logic [5:0] LAMP_G00   = 6'h02;
  localparam logic [5:0] LAMP_G01   = 6'h04;
  localparam logic [5:0] LAMP_G02   = 6'h08;
  localparam logic [5:0] LAMP_G03   = 6'h10;
  localparam logic [5:0] LAMP_G04   = 6'h20;

  // Host bytes by the number of line edges they carry (falls plus one)
  localparam byte_t HB_EDGES1 = 8'h00;
  localparam byte_t HB_EDGES2 = 8'h01;
  localparam byte_t HB_EDGES3 = 8'h05;
  localparam byte_t HB_EDGES4 = 8'h15;
  localparam byte_t HB_PREFIX = 8'h55;

  typedef struct {
    logic       byte_valid;
    byte_t      tx_byte;
    logic       last;
    logic [5:0] led_mask;
    logic       beep_active;
  } tx_result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [15:0]         cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_action;
  logic [KEY_BITS-1:0] in_key_id;
  logic [7:0]          in_scancode;
  logic [3:0]          in_tick_ms;
  logic [7:0]          in_host_byte;
  logic                out_valid;
  logic                out_stall;
  logic                out_byte_valid;
  logic [7:0]          out_tx_byte;
  logic                out_last;
  logic [5:0]          out_led_mask;
  logic                out_beep_active;

  keyboard_repeat_and_command_top #(
    .KEY_ID_BITS(KEY_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_key_id      (in_key_id),
    .in_scancode    (in_scancode),
    .in_tick_ms     (in_tick_ms),
    .in_host_byte   (in_host_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte_valid (out_byte_valid),
    .out_tx_byte    (out_tx_byte),
    .out_last       (out_last),
    .out_led_mask   (out_led_mask),
    .out_beep_active(out_beep_active)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the registers and state
  ms16_t      cfg_delay;
  ms16_t      cfg_period;
  byte_t      cfg_type;
  ms16_t      cfg_beep;
  key_t       held_key;
  byte_t      held_sc;
  int         delay_left;
  int         period_left;
  logic [3:0] edge_count;
  logic [5:0] lamps;
  int         beep_left;

  tx_result_t expected_bytes[$];
  int         error_count = 0;
  bit         tx_gaps     = 1'b0;
  bit         rx_stalls   = 1'b0;
  int         stall_left  = 0;

  task automatic note_error(input string msg);
    if (error_count < ERR_PRINTS)
      $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [3:0] line_edges(input byte_t b);
    logic       prev;
    logic [3:0] n;
    n    = 4'd1;
    prev = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (prev && !b[i]) n++;
      prev = b[i];
    end
    return n;
  endfunction

  function automatic int eff_delay();
    return (cfg_delay == '0) ? 1 : int'(cfg_delay);
  endfunction

  function automatic int eff_period();
    return (cfg_period == '0) ? 1 : int'(cfg_period);
  endfunction

  // Works out the result items that one accepted event causes
  task automatic predict_event(input action_t act, input key_t key, input byte_t sc,
                               input logic [3:0] tick, input byte_t hb);
    byte_t      sent[$];
    tx_result_t r;
    int         dt;
    int         n;
    logic [3:0] code;
    dt = int'(tick);
    case (act)
      ACT_PRESS: begin
        held_key    = key;
        held_sc     = sc;
        delay_left  = eff_delay();
        period_left = 0;
        sent.insert(sent.size(), sc);
      end
      ACT_RELEASE: begin
        // only the held key (or zero with nothing held) clears
        if (held_key == key) begin
          held_key    = '0;
          held_sc     = '0;
          delay_left  = 0;
          period_left = 0;
        end
      end
      ACT_TICK: begin
        beep_left = (beep_left > dt) ? beep_left - dt : 0;
        if (held_key != '0) begin
          if (delay_left > 0) begin
            // initial delay; overshoot carries into the period
            delay_left -= dt;
            if (delay_left <= 0) begin
              sent.insert(sent.size(), held_sc);
              period_left = eff_period() + delay_left;
              if (period_left <= 0) begin
                sent.insert(sent.size(), held_sc);
                period_left = eff_period();
              end
              delay_left = 0;
            end
          end else begin
            period_left -= dt;
            while (period_left <= 0 && sent.size() < MAX_BYTES) begin
              sent.insert(sent.size(), held_sc);
              period_left += eff_period();
            end
            if (period_left <= 0) period_left = eff_period();
          end
        end
      end
      default: begin
        sent.insert(sent.size(), cfg_type);
        edge_count = edge_count + line_edges(hb);
        code       = 4'd15 - edge_count;
        if (code != CMD_PREFIX) begin
          edge_count = '0;
          case (code)
            CMD_ALL_OFF, CMD_ALL_OFF_ALT: begin
              lamps     = '0;
              beep_left = 0;
            end
            CMD_ERROR_LAMP: begin
              lamps ^= LAMP_ERROR;
              if (lamps[0]) beep_left = int'(cfg_beep);
            end
            CMD_BEEP: beep_left = int'(cfg_beep);
            CMD_G00:  lamps ^= LAMP_G00;
            CMD_G01:  lamps ^= LAMP_G01;
            CMD_G02:  lamps ^= LAMP_G02;
            CMD_G03:  lamps ^= LAMP_G03;
            CMD_G04:  lamps ^= LAMP_G04;
            default: ;
          endcase
        end
      end
    endcase

    // an event with nothing to send still gives one empty item
    n = (sent.size() == 0) ? 1 : sent.size();
    for (int k = 0; k < n; k++) begin
      r.byte_valid  = (sent.size() != 0);
      r.tx_byte     = (sent.size() != 0) ? sent[k] : 8'h00;
      r.last        = (k == n - 1);
      r.led_mask    = lamps;
      r.beep_active = (beep_left != 0);
      expected_bytes.insert(expected_bytes.size(), r);
    end
  endtask

  // Sends one item, after a random gap when tx_gaps is set, and predicts on acceptance
  task automatic send_event(input action_t act, input key_t key, input byte_t sc,
                            input logic [3:0] tick, input byte_t hb);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 11) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_action    <= act;
    in_key_id    <= key;
    in_scancode  <= sc;
    in_tick_ms   <= tick;
    in_host_byte <= hb;
    do @(posedge clk); while (in_stall);
    predict_event(act, key, sc, tick, hb);
  endtask

  // Wrappers fill the fields an event does not use with noise
  task automatic key_down(input key_t key, input byte_t sc);
    send_event(ACT_PRESS, key, sc, 4'($urandom), 8'($urandom));
  endtask

  task automatic key_up(input key_t key);
    send_event(ACT_RELEASE, key, 8'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic tick_event(input logic [3:0] ms);
    send_event(ACT_TICK, 16'($urandom), 8'($urandom), ms, 8'($urandom));
  endtask

  task automatic host_cmd(input byte_t b);
    send_event(ACT_HOST, 16'($urandom), 8'($urandom), 4'($urandom), b);
  endtask

  // Sender pauses until every expected item has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_REPEAT_DELAY:  cfg_delay  = data;
      REG_REPEAT_PERIOD: cfg_period = data;
      REG_TYPE_CODE:     cfg_type   = data[7:0];
      default:           cfg_beep   = data;
    endcase
  endtask

  // Result side: random stall per item when rx_stalls is set, check on every accepted item
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    tx_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        note_error($sformatf("unexpected item, tx_byte %02h", out_tx_byte));
      end else begin
        want = expected_bytes[0];
        expected_bytes.delete(0);
        if (out_byte_valid !== want.byte_valid)
          note_error($sformatf("byte_valid %b, expected %b", out_byte_valid, want.byte_valid));
        if (out_tx_byte !== want.tx_byte)
          note_error($sformatf("tx_byte %02h, expected %02h", out_tx_byte, want.tx_byte));
        if (out_last !== want.last)
          note_error($sformatf("last %b, expected %b", out_last, want.last));
        if (out_led_mask !== want.led_mask)
          note_error($sformatf("led_mask %02h, expected %02h", out_led_mask, want.led_mask));
        if (out_beep_active !== want.beep_active)
          note_error($sformatf("beep_active %b, expected %b", out_beep_active,
                               want.beep_active));
      end
      stall_left = rx_stalls ? $urandom_range(0, 11) : 0;
    end
  end

  // Reset values: press, tick, beep command and both kinds of release
  task automatic test_reset_defaults();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    key_down(16'hFFFF, 8'hFF);
    tick_event(4'd15);
    host_cmd(HB_EDGES3);
    key_up(16'h1234);
    key_up(16'hFFFF);
  endtask

  // Zero timing registers act as 1 ms: a tick can give the full 15 bytes
  task automatic test_zero_timing_repeat();
    wait_drained();
    write_reg(REG_REPEAT_DELAY, 16'h0000);
    write_reg(REG_REPEAT_PERIOD, 16'h0000);
    key_down(16'h0001, 8'h00);
    tick_event(4'd15);
    tick_event(4'd15);
    // key zero sends its code but never repeats
    key_down(16'h0000, 8'h5A);
    tick_event(4'd15);
  endtask

  // Each command but the beep; G01 to G04 and the second clear use the prefix byte
  task automatic test_command_decode();
    host_cmd(HB_EDGES2);
    host_cmd(HB_EDGES4);
    host_cmd(HB_EDGES1);
    host_cmd(HB_EDGES2);
    host_cmd(HB_PREFIX);
    host_cmd(HB_EDGES2);
    host_cmd(HB_PREFIX);
    host_cmd(HB_EDGES3);
    host_cmd(HB_PREFIX);
    host_cmd(HB_EDGES4);
    host_cmd(HB_PREFIX);
    host_cmd(HB_PREFIX);
    host_cmd(HB_PREFIX);
    host_cmd(HB_EDGES1);
  endtask

  // Register extremes
  task automatic test_config_extremes();
    wait_drained();
    write_reg(REG_REPEAT_DELAY, 16'hFFFF);
    write_reg(REG_REPEAT_PERIOD, 16'hFFFF);
    write_reg(REG_TYPE_CODE, 16'hFFFF);
    write_reg(REG_BEEP_MS, 16'h0000);
    key_down(16'h8000, 8'h81);
    tick_event(4'd15);
    host_cmd(HB_EDGES3);
    wait_drained();
    write_reg(REG_REPEAT_DELAY, 16'h0001);
    write_reg(REG_TYPE_CODE, 16'hFF00);
    write_reg(REG_BEEP_MS, 16'hFFFF);
    key_down(16'h7FFF, 8'h7E);
    tick_event(4'd1);
    tick_event(4'd15);
    host_cmd(HB_EDGES3);
    key_up(16'h7FFF);
  endtask

  // Mostly press-tick-release sequences and commands, some noise
  task automatic random_phase(input int n_items);
    int    sent_items;
    int    pick;
    int    n_ticks;
    key_t  key;
    sent_items = 0;
    while (sent_items < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        key = ($urandom_range(0, 9) == 0) ? '0 : key_t'($urandom);
        key_down(key, 8'($urandom));
        n_ticks = $urandom_range(1, 8);
        repeat (n_ticks) tick_event(4'($urandom));
        sent_items += n_ticks + 1;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          key_up(key);
          sent_items++;
        end else if (pick < 9) begin
          key_up(key_t'($urandom));
          sent_items++;
        end
      end else if (pick < 80) begin
        if ($urandom_range(0, 4) < 2) begin
          host_cmd(HB_PREFIX);
          sent_items++;
        end
        host_cmd(8'($urandom));
        sent_items++;
      end else begin
        send_event(action_t'($urandom_range(0, 3)), key_t'($urandom), 8'($urandom),
                   4'($urandom), 8'($urandom));
        sent_items++;
      end
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      write_reg(REG_REPEAT_DELAY, ($urandom_range(0, 3) == 0) ? 16'd0 :
                16'($urandom_range(1, 40)));
      write_reg(REG_REPEAT_PERIOD, 16'($urandom_range(0, 12)));
      write_reg(REG_TYPE_CODE, 16'($urandom));
      write_reg(REG_BEEP_MS, ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                16'($urandom_range(0, 120)));
      // first phase runs flat out on both sides
      tx_gaps   = (p != 0) && ($urandom_range(0, 3) != 0);
      rx_stalls = (p != 0) && ($urandom_range(0, 3) != 0);
      random_phase(86);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_action    = ACT_PRESS;
    in_key_id    = '0;
    in_scancode  = '0;
    in_tick_ms   = '0;
    in_host_byte = '0;
    out_stall    = 1'b0;

    cfg_delay   = 16'd500;
    cfg_period  = 16'd100;
    cfg_type    = 8'd128;
    cfg_beep    = 16'd1000;
    held_key    = '0;
    held_sc     = '0;
    delay_left  = 0;
    period_left = 0;
    edge_count  = '0;
    lamps       = '0;
    beep_left   = 0;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_zero_timing_repeat();
    test_command_decode();
    test_config_extremes();
    test_random_traffic();
    wait_drained();

    if (expected_bytes.size() != 0)
      note_error($sformatf("%0d items never arrived", expected_bytes.size()));
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/kbrc_pkg.sv
rtl/kbrc_front.sv
rtl/kbrc_back.sv
rtl/keyboard_repeat_and_command_top.sv
tb/keyboard_repeat_and_command_top_tb.sv
